### sv/bag_pkg.sv
// ----------------------------------------------------------------------------
// bag_pkg - shared types and constants for the button arm guard
// Holds the arm mode encoding, register indexes, reset values and the
// result word carried from the core to the output register.
// ----------------------------------------------------------------------------
package bag_pkg;

	// arm mode encoding
	typedef enum logic [1:0] {
		MODE_DISARMED = 2'd0,
		MODE_TIMED    = 2'd1,
		MODE_EXTENDED = 2'd2
	} mode_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd1;

	// register width and reset values
	localparam int unsigned CFG_W = 16;
	localparam logic [CFG_W-1:0] TIMEOUT_RESET    = 16'd600;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd60;

	// default width of the tick counters
	localparam int unsigned AGE_BITS_DEFAULT = 16;

	// one result word
	typedef struct packed {
		logic armed;
		logic extended;
		logic armed_pulse;
		logic timed_out;
	} result_t;

endpackage

### sv/button_arm_guard.sv
// Path: an accepted word is held in the input register, and its result is then written to the result register.
// Throughput: one word per cycle; while a result waits, the input register
// takes one more word and then stalls the input until the result is taken.
// The pace is set by the state update in the core.
// Reset: mode disarmed, level released, ages clear, registers 600 and 60.
// ----------------------------------------------------------------------------
// button_arm_guard - top level of the button arm guard
// Input register, per-tick arm logic and result register with valid/stall
// handshakes, plus the two configuration registers.
// ----------------------------------------------------------------------------
module button_arm_guard #(
	parameter int unsigned AGE_BITS = bag_pkg::AGE_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic [bag_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bag_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          button_level,
	input  logic                          consume,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          armed,
	output logic                          extended,
	output logic                          armed_pulse,
	output logic                          timed_out
);
	import bag_pkg::*;

	logic             valid_s1;
	logic             level_s1;
	logic             consume_s1;
	logic             out_valid_q;
	result_t          result_q;
	result_t          result_d;
	logic             advance;
	logic             load_s1;
	logic [CFG_W-1:0] timeout_q;
	logic [CFG_W-1:0] long_press_q;

	// move the held word on when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load_s1  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TIMEOUT:    timeout_q    <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			level_s1   <= button_level;
			consume_s1 <= consume;
		end
	end

	bag_core #(
		.AGE_BITS(AGE_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.level           (level_s1),
		.consume         (consume_s1),
		.timeout_ticks   (timeout_q),
		.long_press_ticks(long_press_q),
		.result          (result_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign armed       = result_q.armed;
	assign extended    = result_q.extended;
	assign armed_pulse = result_q.armed_pulse;
	assign timed_out   = result_q.timed_out;

	// a fresh press arms the timed mode and cannot expire in the same tick
	a_pulse_timed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.armed_pulse |->
			result_q.armed && !result_q.extended && !result_q.timed_out)
		else $error("press pulse without a plain timed arm");

	// extended implies armed, expiry implies disarmed
	a_mode_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!result_q.extended || result_q.armed) &&
			(!result_q.timed_out || !result_q.armed))
		else $error("inconsistent arm flags");

	// input stalls only while the input register holds a blocked word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked result");

	// a blocked result keeps its word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(result_q))
		else $error("stalled result changed");

endmodule

### sv/bag_core.sv
// ----------------------------------------------------------------------------
// bag_core - arm mode state and per-tick update
// Keeps mode, last level, press tracking and the two saturating ages, and
// works out one tick's next state and result word in a single pass.
// ----------------------------------------------------------------------------
module bag_core #(
	parameter int unsigned AGE_BITS = bag_pkg::AGE_BITS_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    level,
	input  logic                    consume,
	input  logic [bag_pkg::CFG_W-1:0] timeout_ticks,
	input  logic [bag_pkg::CFG_W-1:0] long_press_ticks,
	output bag_pkg::result_t        result
);
	import bag_pkg::*;

	localparam int unsigned CMP_W = (AGE_BITS > CFG_W) ? AGE_BITS : CFG_W;

	mode_t               mode_q, mode_d;
	logic                prev_level_q, prev_level_d;
	logic                tracked_q, tracked_d;
	logic [AGE_BITS-1:0] press_age_q, press_age_d;
	logic [AGE_BITS-1:0] arm_age_q, arm_age_d;
	logic [AGE_BITS-1:0] press_age_inc, arm_age_inc;
	logic                pulse_d, expired_d;
	logic                lvl_edge;
	mode_t               mode_mid;

	// saturating age bump
	assign press_age_inc = (&press_age_q) ? press_age_q : press_age_q + 1'b1;
	assign arm_age_inc   = (&arm_age_q) ? arm_age_q : arm_age_q + 1'b1;
	assign lvl_edge      = (level != prev_level_q);

	// next state for one tick
	always_comb begin
		mode_mid     = consume ? MODE_DISARMED : mode_q;
		prev_level_d = level;
		tracked_d    = tracked_q;
		press_age_d  = press_age_inc;
		arm_age_d    = arm_age_inc;
		pulse_d      = 1'b0;
		expired_d    = 1'b0;
		if (lvl_edge && !level) begin
			press_age_d = '0;
			arm_age_d   = '0;
			tracked_d   = 1'b1;
			mode_mid    = MODE_TIMED;
			pulse_d     = 1'b1;
		end else if (lvl_edge) begin
			tracked_d = 1'b0;
		end else if (!level && tracked_q &&
				(CMP_W'(press_age_inc) > CMP_W'(long_press_ticks))) begin
			mode_mid = MODE_EXTENDED;
		end
		mode_d = mode_mid;
		// expire an old timed arm
		if (mode_mid == MODE_TIMED && (CMP_W'(arm_age_d) > CMP_W'(timeout_ticks))) begin
			mode_d    = MODE_DISARMED;
			expired_d = 1'b1;
		end
	end

	// result word from the new mode
	always_comb begin
		result.armed_pulse = pulse_d;
		result.timed_out   = expired_d;
		case (mode_d)
			MODE_TIMED: begin
				result.armed    = 1'b1;
				result.extended = 1'b0;
			end
			MODE_EXTENDED: begin
				result.armed    = 1'b1;
				result.extended = 1'b1;
			end
			default: begin
				result.armed    = 1'b0;
				result.extended = 1'b0;
			end
		endcase
	end

	// commit the state when the word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_DISARMED;
			prev_level_q <= 1'b1;
			tracked_q    <= 1'b0;
			press_age_q  <= '0;
			arm_age_q    <= '0;
		end else if (advance) begin
			mode_q       <= mode_d;
			prev_level_q <= prev_level_d;
			tracked_q    <= tracked_d;
			press_age_q  <= press_age_d;
			arm_age_q    <= arm_age_d;
		end
	end

endmodule
